/* src/jsse_pkg.sv */
// Shared types, constants and header table for the JPEG SOF0 size extractor.
package jsse_pkg;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] CODE_SOF0     = 8'hC0;

    localparam logic [3:0] HDR_SOI_LAST  = 4'd3;
    localparam logic [3:0] HDR_LEN_HI    = 4'd4;
    localparam logic [3:0] HDR_LEN_LO    = 4'd5;
    localparam logic [3:0] HDR_ID_LAST   = 4'd10;
    localparam logic [15:0] APP0_MIN_LEN = 16'd7;
    localparam logic [15:0] SEG_MIN_LEN  = 16'd2;

    localparam logic [3:0] SOF_HEIGHT_HI = 4'd3;
    localparam logic [3:0] SOF_HEIGHT_LO = 4'd4;
    localparam logic [3:0] SOF_WIDTH_HI  = 4'd5;
    localparam logic [3:0] SOF_WIDTH_LO  = 4'd6;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_SOI   = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_LOST      = 3'd3,
        ST_EARLY_END = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_MARKER = 6'b000010,
        PH_CODE   = 6'b000100,
        PH_LENGTH = 6'b001000,
        PH_SKIP   = 6'b010000,
        PH_SOF    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic        size_found;
        status_t     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

    // Expected bytes of FF D8 FF E0 len len "JFIF" 00
    function automatic logic [7:0] header_byte(input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'hFF;
            4'd1:    b = 8'hD8;
            4'd2:    b = 8'hFF;
            4'd3:    b = 8'hE0;
            4'd6:    b = 8'h4A;
            4'd7:    b = 8'h46;
            4'd8:    b = 8'h49;
            4'd9:    b = 8'h46;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/jsse_in_reg.sv */
// Input register stage for the byte stream.
module jsse_in_reg
    import jsse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* src/jsse_parser.sv */
// Marker walk state and per-byte decode logic.
module jsse_parser
    import jsse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    phase_t      phase_reg,  phase_next;
    logic [3:0]  pos_reg,    pos_next;
    logic [15:0] skip_reg,   skip_next;
    logic [7:0]  lhb_reg,    lhb_next;
    logic [15:0] width_reg,  width_next;
    logic [15:0] height_reg, height_next;
    logic        decided_reg, decided_next;

    logic        fail;
    status_t     st;
    logic [7:0]  b;
    logic [15:0] seg_len;
    logic [15:0] app0_rest;

    assign b         = item.byte_value;
    assign seg_len   = {lhb_reg, b};
    assign app0_rest = skip_reg - APP0_MIN_LEN;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        lhb_next     = lhb_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        decided_next = decided_reg;
        fail         = 1'b0;
        st           = ST_LOST;

        if (!decided_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg <= HDR_SOI_LAST)
                    begin
                        if (b != header_byte(pos_reg))
                        begin
                            fail = 1'b1;
                            st   = ST_BAD_SOI;
                        end
                    end
                    else if (pos_reg == HDR_LEN_HI)
                    begin
                        lhb_next = b;
                    end
                    else if (pos_reg == HDR_LEN_LO)
                    begin
                        skip_next = seg_len;
                    end
                    else if (pos_reg <= HDR_ID_LAST)
                    begin
                        if (b != header_byte(pos_reg))
                        begin
                            fail = 1'b1;
                            st   = ST_BAD_ID;
                        end
                        else if (pos_reg == HDR_ID_LAST)
                        begin
                            if (skip_reg < APP0_MIN_LEN)
                            begin
                                fail = 1'b1;
                                st   = ST_LOST;
                            end
                            else
                            begin
                                skip_next  = app0_rest;
                                phase_next = (app0_rest != 16'd0) ? PH_SKIP : PH_MARKER;
                            end
                        end
                    end
                    pos_next = pos_reg + 4'd1;
                end
                PH_MARKER:
                begin
                    if (b != MARKER_PREFIX)
                    begin
                        fail = 1'b1;
                        st   = ST_LOST;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    pos_next   = 4'd0;
                    phase_next = (b == CODE_SOF0) ? PH_SOF : PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (pos_reg == 4'd0)
                    begin
                        lhb_next = b;
                        pos_next = 4'd1;
                    end
                    else if (seg_len < SEG_MIN_LEN)
                    begin
                        fail = 1'b1;
                        st   = ST_LOST;
                    end
                    else
                    begin
                        skip_next  = seg_len - SEG_MIN_LEN;
                        phase_next = (seg_len != SEG_MIN_LEN) ? PH_SKIP : PH_MARKER;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_reg == 16'd1)
                    begin
                        phase_next = PH_MARKER;
                    end
                end
                PH_SOF:
                begin
                    if (pos_reg == SOF_HEIGHT_HI || pos_reg == SOF_HEIGHT_LO)
                    begin
                        height_next = {height_reg[7:0], b};
                    end
                    else if (pos_reg >= SOF_WIDTH_HI)
                    begin
                        width_next = {width_reg[7:0], b};
                    end
                    if (pos_reg >= SOF_WIDTH_LO)
                    begin
                        fail = 1'b1;
                        st   = ST_FOUND;
                    end
                    pos_next = pos_reg + 4'd1;
                end
                default:
                begin
                    fail = 1'b1;
                    st   = ST_LOST;
                end
            endcase

            if (!fail && item.end_of_file)
            begin
                fail = 1'b1;
                st   = ST_EARLY_END;
            end
            if (fail)
            begin
                decided_next = 1'b1;
            end
        end

        res_valid = fail;
        res.size_found   = (st == ST_FOUND);
        res.status       = st;
        res.image_width  = (st == ST_FOUND) ? width_next  : 16'd0;
        res.image_height = (st == ST_FOUND) ? height_next : 16'd0;

        if (item.end_of_file)
        begin
            phase_next   = PH_HEADER;
            pos_next     = 4'd0;
            skip_next    = 16'd0;
            lhb_next     = 8'd0;
            width_next   = 16'd0;
            height_next  = 16'd0;
            decided_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= 4'd0;
            skip_reg    <= 16'd0;
            lhb_reg     <= 8'd0;
            width_reg   <= 16'd0;
            height_reg  <= 16'd0;
            decided_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            lhb_reg     <= lhb_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            decided_reg <= decided_next;
        end
    end

    a_quiet_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg |-> !res_valid)
        else $error("result raised after file was decided");

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.end_of_file |=> phase_reg == PH_HEADER && !decided_reg && pos_reg == 4'd0)
        else $error("final byte did not restart the parser");

    a_found_from_sof: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_FOUND |-> phase_reg == PH_SOF && pos_reg >= SOF_WIDTH_LO)
        else $error("size reported outside SOF0 segment");

endmodule

/* src/jsse_out_reg.sv */
// Result register for the output stream.
module jsse_out_reg
    import jsse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

/* src/jpeg_sof0_size_extractor.sv */
// The result register loads a beat as the deciding byte leaves the input register.
// Throughput: one byte per cycle unless m_axis stalls; one result beat per file.
// An input register and a result register separate the two stream sides.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to the start of a file.
module jpeg_sof0_size_extractor
    import jsse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] image_width, [31:16] image_height
    output logic [3:0]  m_axis_tuser    // [0] size_found, [3:1] status
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  out_res;

    assign in_item.byte_value  = s_axis_tdata;
    assign in_item.end_of_file = s_axis_tlast;

    assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

    jsse_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jsse_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    jsse_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.image_height, out_res.image_width};
    assign m_axis_tuser = {out_res.status, out_res.size_found};

endmodule

/* bench/tb.sv */
// Self-checking testbench for the JPEG SOF0 size extractor: byte stream in, size/status out.
`timescale 1ns / 100ps

module tb;
    import jsse_pkg::*;

    // FF D8 FF E0 len len J F I F 00, first byte in the lowest bits
    localparam logic [87:0] JFIF_PREFIX = {8'h00, 8'h46, 8'h49, 8'h46, 8'h4A,
                                           8'h00, 8'h00, 8'hE0, 8'hFF, 8'hD8, 8'hFF};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] byte_value
    logic        s_axis_tlast = 1'b0;   // end_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [15:0] image_width, [31:16] image_height
    logic [3:0]  m_axis_tuser;          // [0] size_found, [3:1] status

    jpeg_sof0_size_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    in_item_t    byte_q[$];
    result_t     sizes_due[$];
    logic [7:0]  file_bytes[$];
    in_item_t    on_bus;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          tx_wait = 0;
    int          tx_calm = 0;
    int          rx_wait = 0;
    int          rx_calm = 0;
    logic        hold_rx = 1'b0;

    // parser mirror
    phase_t      ph = PH_HEADER;
    logic [3:0]  pos = 4'd0;
    logic [15:0] skip_left = 16'd0;
    logic [7:0]  len_hi = 8'd0;
    logic [15:0] width_acc = 16'd0;
    logic [15:0] height_acc = 16'd0;
    bit          decided = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int next_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 8);
    endfunction

    task automatic track_byte(input in_item_t it);
        logic [7:0]  b;
        logic [15:0] seg_len;
        bit          hit;
        status_t     verdict;
        result_t     r;
        b = it.byte_value;
        hit = 1'b0;
        verdict = ST_LOST;
        if (!decided)
        begin
            case (ph)
                PH_HEADER:
                begin
                    if (pos < 4'd4)
                    begin
                        if (b != JFIF_PREFIX[8*pos +: 8])
                        begin
                            hit = 1'b1;
                            verdict = ST_BAD_SOI;
                        end
                    end
                    else if (pos == 4'd4)
                        len_hi = b;
                    else if (pos == 4'd5)
                        skip_left = {len_hi, b};
                    else if (pos <= 4'd10)
                    begin
                        if (b != JFIF_PREFIX[8*pos +: 8])
                        begin
                            hit = 1'b1;
                            verdict = ST_BAD_ID;
                        end
                        else if (pos == 4'd10)
                        begin
                            // APP0 length covers its own 2 bytes and the 5 id bytes
                            if (skip_left < 16'd7)
                                hit = 1'b1;
                            else
                            begin
                                skip_left = skip_left - 16'd7;
                                ph = (skip_left != 16'd0) ? PH_SKIP : PH_MARKER;
                            end
                        end
                    end
                    pos = pos + 4'd1;
                end
                PH_MARKER:
                begin
                    if (b != 8'hFF)
                        hit = 1'b1;
                    else
                        ph = PH_CODE;
                end
                PH_CODE:
                begin
                    pos = 4'd0;
                    ph = (b == 8'hC0) ? PH_SOF : PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (pos == 4'd0)
                    begin
                        len_hi = b;
                        pos = 4'd1;
                    end
                    else
                    begin
                        seg_len = {len_hi, b};
                        if (seg_len < 16'd2)
                            hit = 1'b1;
                        else
                        begin
                            skip_left = seg_len - 16'd2;
                            ph = (skip_left != 16'd0) ? PH_SKIP : PH_MARKER;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0)
                        ph = PH_MARKER;
                end
                PH_SOF:
                begin
                    // length, precision, height hi/lo, width hi/lo
                    if (pos == 4'd3 || pos == 4'd4)
                        height_acc = {height_acc[7:0], b};
                    else if (pos >= 4'd5)
                        width_acc = {width_acc[7:0], b};
                    if (pos >= 4'd6)
                    begin
                        hit = 1'b1;
                        verdict = ST_FOUND;
                    end
                    pos = pos + 4'd1;
                end
                default:
                    hit = 1'b1;
            endcase
            if (!hit && it.end_of_file)
            begin
                hit = 1'b1;
                verdict = ST_EARLY_END;
            end
            if (hit)
            begin
                r.size_found = (verdict == ST_FOUND);
                r.status = verdict;
                r.image_width = (verdict == ST_FOUND) ? width_acc : 16'd0;
                r.image_height = (verdict == ST_FOUND) ? height_acc : 16'd0;
                sizes_due.push_back(r);
                decided = 1'b1;
            end
        end
        if (it.end_of_file)
        begin
            ph = PH_HEADER;
            pos = 4'd0;
            skip_left = 16'd0;
            len_hi = 8'd0;
            width_acc = 16'd0;
            height_acc = 16'd0;
            decided = 1'b0;
        end
    endtask

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tlast <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_byte(on_bus);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    on_bus = byte_q.pop_front();
                    s_axis_tdata <= on_bus.byte_value;
                    s_axis_tlast <= on_bus.end_of_file;
                    s_axis_tvalid <= 1'b1;
                    tx_wait = next_wait(tx_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sizes_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h/%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = sizes_due.pop_front();
                    check_field("size_found", 16'(want.size_found), 16'(m_axis_tuser[0]));
                    check_field("status", 16'(want.status), 16'(m_axis_tuser[3:1]));
                    check_field("image_width", want.image_width, m_axis_tdata[15:0]);
                    check_field("image_height", want.image_height, m_axis_tdata[31:16]);
                end
                rx_wait = next_wait(rx_calm);
            end
            if (hold_rx)
                m_axis_tready <= 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // long receiver stall so the result side backs up into the input
    initial
    begin
        while (bytes_taken < 400)
            @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic add(input logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    // first byte is the most significant of the n given
    task automatic add_seq(input logic [127:0] seq, input int n);
        for (int i = n - 1; i >= 0; i--)
            add(seq[8*i +: 8]);
    endtask

    task automatic add_header(input logic [15:0] app_len);
        add_seq(128'({8'hFF, 8'hD8, 8'hFF, 8'hE0, app_len,
                      8'h4A, 8'h46, 8'h49, 8'h46, 8'h00}), 11);
    endtask

    task automatic add_sof(input logic [15:0] h, input logic [15:0] w);
        add_seq(128'({8'hFF, 8'hC0, 8'h00, 8'h11, 8'h08, h, w}), 9);
    endtask

    task automatic flush_file();
        in_item_t it;
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            it.byte_value = file_bytes[i];
            it.end_of_file = (i == file_bytes.size() - 1);
            byte_q.push_back(it);
        end
        file_bytes.delete();
    endtask

    task automatic add_random_file();
        int app_len;
        int seg_len;
        int cut;
        logic [7:0] code;
        app_len = $urandom_range(7, 14);
        add_header(app_len[15:0]);
        repeat (app_len - 7) add(8'($urandom));
        repeat ($urandom_range(0, 3))
        begin
            code = 8'($urandom);
            if (code == 8'hC0)
                code = 8'hC1;
            seg_len = $urandom_range(2, 8);
            add_seq(128'({8'hFF, code, seg_len[15:0]}), 4);
            repeat (seg_len - 2) add(8'($urandom));
        end
        add_seq(128'({8'hFF, 8'hC0}), 2);
        repeat (7) add(8'($urandom));
        repeat ($urandom_range(0, 3)) add(8'($urandom));
        case ($urandom_range(0, 9))
            0:
            begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
            1, 2:
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            3:
            begin
                file_bytes.delete();
                repeat ($urandom_range(1, 16)) add(8'($urandom));
            end
            default:
                ;
        endcase
        flush_file();
    endtask

    initial
    begin
        int files;
        files = 0;

        add(8'h12);
        flush_file();
        add_seq(128'({8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h55, 8'h66}), 6);
        flush_file();
        add_seq(128'({8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h10,
                      8'h4A, 8'h46, 8'h58, 8'h46, 8'h00}), 11);
        flush_file();
        add_seq(128'({8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h10,
                      8'h4A, 8'h46, 8'h49, 8'h46, 8'h01}), 11);
        flush_file();
        add_header(16'd6);
        add(8'h00);
        flush_file();
        add_header(16'd7);
        add_seq(128'({8'hFF, 8'hDB, 8'h00, 8'h01}), 4);
        flush_file();
        add_header(16'd7);
        add(8'h12);
        flush_file();
        // FF as segment code, max size decided on the last byte
        add_header(16'd9);
        add_seq(128'({8'hAA, 8'hBB, 8'hFF, 8'hFF, 8'h00, 8'h03, 8'h77}), 7);
        add_sof(16'hFFFF, 16'hFFFF);
        flush_file();
        add_header(16'd7);
        add_sof(16'h0000, 16'h0000);
        add_seq(128'({8'hFF, 8'hD9}), 2);
        flush_file();
        add_header(16'd7);
        add_seq(128'({8'hFF, 8'hC0, 8'h00, 8'h11, 8'h08, 8'h01}), 6);
        flush_file();
        add_seq(128'({8'hFF, 8'hD8}), 2);
        flush_file();
        add_header(16'd7);
        add_seq(128'({8'hFF, 8'hE1, 8'h00, 8'h02}), 4);
        add_sof(16'h1234, 16'h5678);
        flush_file();

        while (byte_q.size() < 820 || files < 20)
        begin
            add_random_file();
            files++;
        end

        // segment length with a nonzero high byte
        add_header(16'd7);
        add_seq(128'({8'hFF, 8'hE1, 8'h01, 8'h00}), 4);
        repeat (254) add(8'($urandom));
        add_sof(16'($urandom), 16'($urandom));
        flush_file();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (sizes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
